### rtl/core/dsmd_pkg.sv
// Package for the dual sensor marker detector: opcodes, register indexes,
// widths, limits and small helper functions. No dependencies.
`default_nettype none

package dsmd_pkg;

    localparam int SAMPLE_W = 12;
    localparam int RUN_W    = 10;
    localparam int MARKER_W = 2;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4095;
    localparam logic [SAMPLE_W-1:0] WIN_LOW    = 12'd50;
    localparam logic [SAMPLE_W-1:0] WIN_HIGH   = 12'd1000;
    localparam logic [RUN_W-1:0]    RUN_MAX    = 10'd1023;

    localparam logic [SAMPLE_W-1:0] DEFAULT_THRESHOLD_RST = 12'd500;
    localparam logic [RUN_W-1:0]    DETECT_CYCLES_RST     = 10'd5;
    localparam logic [RUN_W-1:0]    RELEASE_CYCLES_RST    = 10'd10;

    typedef enum logic [OP_W-1:0] {
        OP_CHECK     = 2'd0,
        OP_CALIBRATE = 2'd1,
        OP_FINALIZE  = 2'd2,
        OP_CAL_RESET = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEFAULT_THRESHOLD = 2'd0,
        CFG_DETECT_CYCLES     = 2'd1,
        CFG_RELEASE_CYCLES    = 2'd2,
        CFG_UNUSED            = 2'd3
    } cfg_index_t;

    localparam logic [MARKER_W-1:0] MARKER_NONE = 2'd0;

    // Saturating increment of a run counter.
    function automatic logic [RUN_W-1:0] run_inc(input logic [RUN_W-1:0] v);
        logic [RUN_W-1:0] r;
        r = (v >= RUN_MAX) ? RUN_MAX : v + 1'b1;
        return r;
    endfunction

    // Midpoint of the calibrated range, with the fallback to the default
    // when nothing was sampled or the midpoint leaves the valid window.
    function automatic logic [SAMPLE_W-1:0] midpoint_level(
        input logic [SAMPLE_W-1:0] lo,
        input logic [SAMPLE_W-1:0] hi,
        input logic [SAMPLE_W-1:0] dflt
    );
        logic [SAMPLE_W-1:0] span;
        logic [SAMPLE_W-1:0] mid;
        logic [SAMPLE_W-1:0] r;
        span = hi - lo;
        mid  = lo + (span >> 1);
        if (lo > hi)
            r = dflt;
        else if (mid < WIN_LOW || mid > WIN_HIGH)
            r = dflt;
        else
            r = mid;
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/dual_sensor_marker_detector.sv
// Dual sensor marker detector: calibration of two thresholds and a debounced
// marker detector, one word per cycle unless the result side stalls. Depends on dsmd_pkg.
// Input words pass the input register, then the result register; the input
// register feeds the detector logic and the result register, and both
// advance whenever the result side takes, one word per cycle unless it stalls.
// Reset (rst_n, asynchronous, active low): detector idle, counters zero,
// min trackers at full scale, max trackers zero, thresholds and registers at
// their documented reset values, both pipeline registers empty.
`default_nettype none

module dual_sensor_marker_detector
    import dsmd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Input words.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // right_sample[11:0], left_sample[23:12]
    input  wire logic [OP_W-1:0]       s_tuser,   // opcode[1:0]

    // Result words.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // marker[1:0], right_level[13:2],
                                                  // left_level[25:14], zero[31:26]

    // Configuration writes.
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers.
    logic [SAMPLE_W-1:0] default_threshold_reg;
    logic [RUN_W-1:0]    detect_cycles_reg;
    logic [RUN_W-1:0]    release_cycles_reg;

    // Pipeline control and payload.
    logic                s1_valid_reg;
    logic [OP_W-1:0]     s1_op_reg;
    logic [SAMPLE_W-1:0] s1_right_reg;
    logic [SAMPLE_W-1:0] s1_left_reg;
    logic                out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                s1_go;

    // Detector and calibration state.
    logic                detecting_reg, detecting_next;
    logic                seen_left_reg, seen_left_next;
    logic                seen_right_reg, seen_right_next;
    logic [RUN_W-1:0]    left_run_reg, left_run_next;
    logic [RUN_W-1:0]    right_run_reg, right_run_next;
    logic [RUN_W-1:0]    clear_run_reg, clear_run_next;
    logic [SAMPLE_W-1:0] right_min_reg, right_min_next;
    logic [SAMPLE_W-1:0] right_max_reg, right_max_next;
    logic [SAMPLE_W-1:0] left_min_reg, left_min_next;
    logic [SAMPLE_W-1:0] left_max_reg, left_max_next;
    logic [SAMPLE_W-1:0] right_thr_reg, right_thr_next;
    logic [SAMPLE_W-1:0] left_thr_reg, left_thr_next;
    logic [MARKER_W-1:0] marker_next;

    // Check-step helpers, computed from the word in the input register.
    logic                l_on;
    logic                r_on;
    logic [RUN_W-1:0]    left_run_cand;
    logic [RUN_W-1:0]    right_run_cand;
    logic [RUN_W-1:0]    clear_run_cand;
    logic                l_hit;
    logic                r_hit;
    logic                event_start;
    logic                event_end;
    logic                seen_left_acc;
    logic                seen_right_acc;

    // The input register moves on when the result register is empty or is
    // being emptied in this cycle, so a word can enter every cycle while the result side takes.
    assign s1_go    = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_go;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A sensor is active when its sample is below its threshold.
    assign l_on = s1_left_reg < left_thr_reg;
    assign r_on = s1_right_reg < right_thr_reg;

    // Idle: run counters count consecutive active checks per sensor.
    assign left_run_cand  = l_on ? run_inc(left_run_reg) : '0;
    assign right_run_cand = r_on ? run_inc(right_run_reg) : '0;
    assign l_hit          = left_run_cand >= detect_cycles_reg;
    assign r_hit          = right_run_cand >= detect_cycles_reg;
    assign event_start    = !detecting_reg && (l_hit || r_hit);

    // Detecting: gather which sensors were seen; the event ends once both
    // sensors have stayed clear for the release count.
    assign clear_run_cand = (!l_on && !r_on) ? run_inc(clear_run_reg) : '0;
    assign event_end      = detecting_reg && (clear_run_cand >= release_cycles_reg);
    assign seen_left_acc  = seen_left_reg || l_on;
    assign seen_right_acc = seen_right_reg || r_on;

    always_comb
    begin
        detecting_next  = detecting_reg;
        seen_left_next  = seen_left_reg;
        seen_right_next = seen_right_reg;
        left_run_next   = left_run_reg;
        right_run_next  = right_run_reg;
        clear_run_next  = clear_run_reg;
        right_min_next  = right_min_reg;
        right_max_next  = right_max_reg;
        left_min_next   = left_min_reg;
        left_max_next   = left_max_reg;
        right_thr_next  = right_thr_reg;
        left_thr_next   = left_thr_reg;
        marker_next     = MARKER_NONE;

        case (opcode_t'(s1_op_reg))
            OP_CHECK:
            begin
                if (!detecting_reg) begin
                    if (event_start) begin
                        seen_left_next  = l_hit;
                        seen_right_next = r_hit;
                        left_run_next   = '0;
                        right_run_next  = '0;
                        clear_run_next  = '0;
                        detecting_next  = 1'b1;
                    end else begin
                        left_run_next   = left_run_cand;
                        right_run_next  = right_run_cand;
                    end
                end else begin
                    if (event_end) begin
                        marker_next     = {seen_right_acc, seen_left_acc};
                        seen_left_next  = 1'b0;
                        seen_right_next = 1'b0;
                        clear_run_next  = '0;
                        detecting_next  = 1'b0;
                    end else begin
                        seen_left_next  = seen_left_acc;
                        seen_right_next = seen_right_acc;
                        clear_run_next  = clear_run_cand;
                    end
                end
            end
            OP_CALIBRATE:
            begin
                if (s1_right_reg < right_min_reg) right_min_next = s1_right_reg;
                if (s1_right_reg > right_max_reg) right_max_next = s1_right_reg;
                if (s1_left_reg < left_min_reg)   left_min_next  = s1_left_reg;
                if (s1_left_reg > left_max_reg)   left_max_next  = s1_left_reg;
            end
            OP_FINALIZE:
            begin
                right_thr_next = midpoint_level(right_min_reg, right_max_reg,
                                                default_threshold_reg);
                left_thr_next  = midpoint_level(left_min_reg, left_max_reg,
                                                default_threshold_reg);
            end
            OP_CAL_RESET:
            begin
                right_min_next = SAMPLE_MAX;
                right_max_next = '0;
                left_min_next  = SAMPLE_MAX;
                left_max_next  = '0;
                right_thr_next = default_threshold_reg;
                left_thr_next  = default_threshold_reg;
            end
            default:
            begin
                marker_next = MARKER_NONE;
            end
        endcase
    end

    // Control state, configuration and detector state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            default_threshold_reg <= DEFAULT_THRESHOLD_RST;
            detect_cycles_reg     <= DETECT_CYCLES_RST;
            release_cycles_reg    <= RELEASE_CYCLES_RST;
            s1_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            detecting_reg         <= 1'b0;
            seen_left_reg         <= 1'b0;
            seen_right_reg        <= 1'b0;
            left_run_reg          <= '0;
            right_run_reg         <= '0;
            clear_run_reg         <= '0;
            right_min_reg         <= SAMPLE_MAX;
            right_max_reg         <= '0;
            left_min_reg          <= SAMPLE_MAX;
            left_max_reg          <= '0;
            right_thr_reg         <= DEFAULT_THRESHOLD_RST;
            left_thr_reg          <= DEFAULT_THRESHOLD_RST;
        end else begin
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_DEFAULT_THRESHOLD: default_threshold_reg <= cfg_wdata;
                    CFG_DETECT_CYCLES:     detect_cycles_reg  <= cfg_wdata[RUN_W-1:0];
                    CFG_RELEASE_CYCLES:    release_cycles_reg <= cfg_wdata[RUN_W-1:0];
                    default:               ;
                endcase
            end

            if (s_tvalid && s_tready)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;

            if (s1_go)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (s1_go) begin
                detecting_reg  <= detecting_next;
                seen_left_reg  <= seen_left_next;
                seen_right_reg <= seen_right_next;
                left_run_reg   <= left_run_next;
                right_run_reg  <= right_run_next;
                clear_run_reg  <= clear_run_next;
                right_min_reg  <= right_min_next;
                right_max_reg  <= right_max_next;
                left_min_reg   <= left_min_next;
                left_max_reg   <= left_max_next;
                right_thr_reg  <= right_thr_next;
                left_thr_reg   <= left_thr_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            s1_op_reg    <= s_tuser;
            s1_right_reg <= s_tdata[SAMPLE_W-1:0];
            s1_left_reg  <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
        end
        if (s1_go) begin
            out_data_reg <= {{(OUT_DATA_W-MARKER_W-2*SAMPLE_W){1'b0}},
                             left_thr_next, right_thr_next, marker_next};
        end
    end

    // While idle no event is half collected.
    assert property (@(posedge clk) disable iff (!rst_n)
        !detecting_reg |-> (clear_run_reg == '0 && !seen_left_reg && !seen_right_reg))
        else $error("idle detector holds event state");

    // While detecting the idle run counters stay cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        detecting_reg |-> (left_run_reg == '0 && right_run_reg == '0))
        else $error("run counters not cleared during an event");

    // An event always has at least one sensor seen.
    assert property (@(posedge clk) disable iff (!rst_n)
        detecting_reg |-> (seen_left_reg || seen_right_reg))
        else $error("event with no sensor seen");

    // A reported marker closes the event.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && marker_next != MARKER_NONE) |=> !detecting_reg)
        else $error("marker reported while event stays open");

    // An empty result register never stalls the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

`default_nettype wire
